// ----- rtl/core/hmtn_pkg.sv -----
// Shared types and fixed-point constants for the heightmap terrain normal generator.
package hmtn_pkg;

    // Field widths fixed by the item formats
    localparam int CFG_W   = 9;
    localparam int HGT_W   = 8;
    localparam int POS_W   = 8;
    localparam int POSY_W  = 12;
    localparam int NRM_W   = 16;
    localparam int TEX_W   = 17;

    // Per-vertex normal sum width (six faces of at most 255 per component)
    localparam int SUM_W   = 12;

    // Unit normal search: magnitude runs over 0..ONE_Q14
    localparam int LO_W    = 15;
    localparam int ONE_Q14 = 16384;
    localparam int LO_TOP  = 14;

    // Face normal y component with heights scaled by twenty
    localparam int FACE_Y  = 20;

    // Height / 20 in Q4.8 is (h*128+5)/10, done as multiply by reciprocal
    localparam int RECIP10    = 52429;
    localparam int RECIP10_SH = 19;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } t_sums;

    typedef struct packed {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } t_norm;

endpackage

// ----- rtl/core/heightmap_terrain_normals_core.sv -----
// Top level: heightmap loader, per-vertex normal accumulation and vertex emitter.
//
// Channel  | Direction | Handshake                         | Payload
// ---------+-----------+-----------------------------------+---------------------------------
// sample   | in        | start & !busy                     | i_height_sample
// vertex   | out       | o_valid, one cycle, no backpressure | pos, normal, tex, last flag
// config   | in        | APB write, psel&penable&pwrite    | grid_width @0x0, grid_depth @0x4
//
// A sample on the top row or left column only stores its height and zeroed sums. A sample
// that completes a grid cell reads three corner heights, updates four sums and then releases
// up to four vertices, skipping the masked corner slots; the normalizer's multiply loop
// (15 bits x 3 components) and the two 17-step texture divisions make up most of each vertex.
// Sums live in one RAM, heights in another.
// Reset is synchronous; the RAMs need no clearing since every vertex's sums are written
// when its own sample loads. Any register write restarts loading at the first sample.
module heightmap_terrain_normals_core #(
    parameter int MAX_GRID_DIM = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [hmtn_pkg::HGT_W-1:0]          i_height_sample,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic                                o_valid,
    output logic [hmtn_pkg::POS_W-1:0]          o_pos_x,
    output logic [hmtn_pkg::POSY_W-1:0]         o_pos_y,
    output logic [hmtn_pkg::POS_W-1:0]          o_pos_z,
    output logic signed [hmtn_pkg::NRM_W-1:0]   o_normal_x,
    output logic signed [hmtn_pkg::NRM_W-1:0]   o_normal_y,
    output logic signed [hmtn_pkg::NRM_W-1:0]   o_normal_z,
    output logic [hmtn_pkg::TEX_W-1:0]          o_tex_u,
    output logic [hmtn_pkg::TEX_W-1:0]          o_tex_v,
    output logic                                o_last_vertex
);

    localparam int DW    = $clog2(MAX_GRID_DIM + 1);
    localparam int CW    = $clog2(MAX_GRID_DIM);
    localparam int DEPTH = MAX_GRID_DIM * MAX_GRID_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = (DW > hmtn_pkg::CFG_W) ? DW : hmtn_pkg::CFG_W;
    localparam int SW    = $bits(hmtn_pkg::t_sums);
    localparam int PYN_W = 15;
    localparam int PYP_W = 32;

    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_DEPTH = 1'b1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HRD  = 4'd1;
    localparam logic [3:0] S_SUM  = 4'd2;
    localparam logic [3:0] S_ESEL = 4'd3;
    localparam logic [3:0] S_ERD  = 4'd4;
    localparam logic [3:0] S_EWT  = 4'd5;
    localparam logic [3:0] S_NORM = 4'd6;
    localparam logic [3:0] S_DIVU = 4'd7;
    localparam logic [3:0] S_DIVV = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    // control and configuration registers
    logic [3:0]                    r_state;
    logic [2:0]                    r_step;
    logic [hmtn_pkg::CFG_W-1:0]    r_gw;
    logic [hmtn_pkg::CFG_W-1:0]    r_gd;
    logic [AW-1:0]                 r_lc;
    logic [CW-1:0]                 r_lrow;
    logic [CW-1:0]                 r_lcol;
    logic [AW-1:0]                 r_f;
    logic [CW-1:0]                 r_row;
    logic [CW-1:0]                 r_col;
    logic [hmtn_pkg::HGT_W-1:0]    r_ha, r_hb, r_he, r_hf, r_h;
    logic [3:0]                    r_mask;
    logic [1:0]                    r_idx;
    hmtn_pkg::t_norm               r_nrm;
    logic [hmtn_pkg::TEX_W-1:0]    r_u;
    logic                          r_strobe;

    // output registers
    logic [hmtn_pkg::POS_W-1:0]    r_pos_x, r_pos_z;
    logic [hmtn_pkg::POSY_W-1:0]   r_pos_y;
    hmtn_pkg::t_norm               r_out_nrm;
    logic [hmtn_pkg::TEX_W-1:0]    r_tex_u, r_tex_v;
    logic                          r_last;

    logic [DW-1:0]                 w, d, wm1, dm1;
    logic [CW-1:0]                 wm1_c, dm1_c;
    logic                          accept, cfg_wr, cell_in, last_c, last_r;
    logic [AW-1:0]                 a_addr, b_addr, e_addr, v_addr;
    logic [CW-1:0]                 v_row, v_col;

    logic                          h_we;
    logic [AW-1:0]                 h_raddr;
    logic [hmtn_pkg::HGT_W-1:0]    h_rdata;
    logic                          s_we;
    logic [AW-1:0]                 s_waddr, s_raddr;
    logic [SW-1:0]                 s_wdata, s_rdata;
    hmtn_pkg::t_sums               sum_rd, n1, n2, n12;

    logic signed [hmtn_pkg::SUM_W-1:0] ha_s, hb_s, he_s, hf_s;

    logic                          norm_start, norm_done;
    hmtn_pkg::t_norm               norm_out;
    logic                          div_start, div_done;
    logic [DW-1:0]                 div_num, div_den;
    logic [hmtn_pkg::TEX_W-1:0]    div_q;

    logic [PYN_W-1:0]              py_num;
    logic [PYP_W-1:0]              py_prod;

    function automatic logic [DW-1:0] f_dim(input logic [hmtn_pkg::CFG_W-1:0] v);
        logic [XW-1:0] vx;
        vx = XW'(v);
        if (vx < XW'(2))                 return DW'(2);
        else if (vx > XW'(MAX_GRID_DIM)) return DW'(MAX_GRID_DIM);
        else                             return DW'(vx);
    endfunction

    function automatic hmtn_pkg::t_sums f_add(input hmtn_pkg::t_sums p,
                                              input hmtn_pkg::t_sums q);
        hmtn_pkg::t_sums s;
        s.x = p.x + q.x;
        s.y = p.y + q.y;
        s.z = p.z + q.z;
        return s;
    endfunction

    // grid size in use and handshakes
    assign w      = f_dim(r_gw);
    assign d      = f_dim(r_gd);
    assign wm1    = w - DW'(1);
    assign dm1    = d - DW'(1);
    assign wm1_c  = CW'(wm1);
    assign dm1_c  = CW'(dm1);
    assign busy   = r_state != S_IDLE;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEPTH) ? 32'(r_gd) : 32'(r_gw);

    assign cell_in = (r_lrow != '0) && (r_lcol != '0);
    assign last_c  = r_lcol == wm1_c;
    assign last_r  = r_lrow == dm1_c;

    // corners of the current cell, f being the sample just loaded
    assign b_addr = r_f - AW'(w);
    assign a_addr = b_addr - AW'(1);
    assign e_addr = r_f - AW'(1);

    // face normals of the two triangles
    assign ha_s = hmtn_pkg::SUM_W'(r_ha);
    assign hb_s = hmtn_pkg::SUM_W'(r_hb);
    assign he_s = hmtn_pkg::SUM_W'(r_he);
    assign hf_s = hmtn_pkg::SUM_W'(r_hf);
    assign n1.x = he_s - hf_s;
    assign n1.y = hmtn_pkg::SUM_W'(hmtn_pkg::FACE_Y);
    assign n1.z = hb_s - hf_s;
    assign n2.x = ha_s - hb_s;
    assign n2.y = hmtn_pkg::SUM_W'(hmtn_pkg::FACE_Y);
    assign n2.z = ha_s - he_s;
    assign n12  = f_add(n1, n2);
    assign sum_rd = hmtn_pkg::t_sums'(s_rdata);

    // vertex being emitted
    assign v_row = r_idx[1] ? r_row : r_row - CW'(1);
    assign v_col = r_idx[0] ? r_col : r_col - CW'(1);
    always_comb begin
        case (r_idx)
            2'd0:    v_addr = a_addr;
            2'd1:    v_addr = b_addr;
            2'd2:    v_addr = e_addr;
            default: v_addr = r_f;
        endcase
    end

    // height memory port control
    assign h_we = accept;
    always_comb begin
        h_raddr = v_addr;
        if (r_state == S_HRD) begin
            case (r_step)
                3'd0:    h_raddr = a_addr;
                3'd1:    h_raddr = b_addr;
                default: h_raddr = e_addr;
            endcase
        end
    end

    // sum memory: read-modify-write of a, b, e, then f written with its first face
    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_lc;
        s_wdata = '0;
        s_raddr = v_addr;
        if (accept && !cell_in) begin
            s_we = 1'b1;
        end
        if (r_state == S_SUM) begin
            case (r_step)
                3'd0:    s_raddr = a_addr;
                3'd1:    s_raddr = b_addr;
                default: s_raddr = e_addr;
            endcase
            case (r_step)
                3'd1: begin
                    s_we = 1'b1; s_waddr = a_addr; s_wdata = f_add(sum_rd, n2);
                end
                3'd2: begin
                    s_we = 1'b1; s_waddr = b_addr; s_wdata = f_add(sum_rd, n12);
                end
                3'd3: begin
                    s_we = 1'b1; s_waddr = e_addr; s_wdata = f_add(sum_rd, n12);
                end
                3'd4: begin
                    s_we = 1'b1; s_waddr = r_f; s_wdata = n1;
                end
                default: s_we = 1'b0;
            endcase
        end
    end

    // normalizer and divider launches
    assign norm_start = r_state == S_EWT;
    assign div_start  = ((r_state == S_NORM) && norm_done) ||
                        ((r_state == S_DIVU) && div_done);
    assign div_num    = (r_state == S_NORM) ? DW'(v_col) : DW'(v_row);
    assign div_den    = (r_state == S_NORM) ? wm1 : dm1;

    // height/20 in Q4.8 via reciprocal of ten
    assign py_num  = PYN_W'({r_h, 7'b0}) + PYN_W'(5);
    assign py_prod = PYP_W'(py_num * 16'(hmtn_pkg::RECIP10));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_gw     <= hmtn_pkg::CFG_W'(256);
            r_gd     <= hmtn_pkg::CFG_W'(256);
            r_lc     <= '0;
            r_lrow   <= '0;
            r_lcol   <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_f    <= r_lc;
                        r_row  <= r_lrow;
                        r_col  <= r_lcol;
                        r_hf   <= i_height_sample;
                        r_mask <= {last_c && last_r, last_r, last_c, 1'b1};
                        r_idx  <= '0;
                        r_step <= '0;
                        r_state <= cell_in ? S_HRD : S_DONE;
                        // advance load position in row-major order
                        if (last_c) begin
                            r_lcol <= '0;
                            if (last_r) begin
                                r_lrow <= '0;
                                r_lc   <= '0;
                            end else begin
                                r_lrow <= r_lrow + CW'(1);
                                r_lc   <= r_lc + AW'(1);
                            end
                        end else begin
                            r_lcol <= r_lcol + CW'(1);
                            r_lc   <= r_lc + AW'(1);
                        end
                    end
                end
                S_HRD: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1:    r_ha <= h_rdata;
                        3'd2:    r_hb <= h_rdata;
                        3'd3:    r_he <= h_rdata;
                        default: ;
                    endcase
                    if (r_step == 3'd3) begin
                        r_step  <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd4) begin
                        r_step  <= '0;
                        r_state <= S_ESEL;
                    end
                end
                S_ESEL: begin
                    if (r_mask[r_idx]) begin
                        r_state <= S_ERD;
                    end else if (r_idx == 2'd3) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_ERD: r_state <= S_EWT;
                S_EWT: begin
                    r_h     <= h_rdata;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (norm_done) begin
                        r_nrm   <= norm_out;
                        r_state <= S_DIVU;
                    end
                end
                S_DIVU: begin
                    if (div_done) begin
                        r_u     <= div_q;
                        r_state <= S_DIVV;
                    end
                end
                S_DIVV: begin
                    if (div_done) begin
                        r_pos_x   <= hmtn_pkg::POS_W'(v_col);
                        r_pos_z   <= hmtn_pkg::POS_W'(v_row);
                        r_pos_y   <= hmtn_pkg::POSY_W'(py_prod >> hmtn_pkg::RECIP10_SH);
                        r_out_nrm <= r_nrm;
                        r_tex_u   <= r_u;
                        r_tex_v   <= div_q;
                        r_last    <= (v_row == dm1_c) && (v_col == wm1_c);
                        r_strobe  <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_idx == 2'd3) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_ESEL;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            // register write restarts loading
            if (cfg_wr) begin
                case (paddr[2])
                    REG_WIDTH: r_gw <= pwdata[hmtn_pkg::CFG_W-1:0];
                    default:   r_gd <= pwdata[hmtn_pkg::CFG_W-1:0];
                endcase
                r_lc   <= '0;
                r_lrow <= '0;
                r_lcol <= '0;
            end
        end
    end

    hmtn_ram #(.WIDTH(hmtn_pkg::HGT_W), .DEPTH(DEPTH)) u_hgt_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (r_lc),
        .i_wdata (i_height_sample),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    hmtn_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    hmtn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_sums  (sum_rd),
        .o_done  (norm_done),
        .o_norm  (norm_out)
    );

    hmtn_div #(.DW(DW)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_num),
        .i_den_m1 (div_den),
        .o_done   (div_done),
        .o_quot   (div_q)
    );

    assign o_valid       = r_strobe;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_pos_z       = r_pos_z;
    assign o_normal_x    = r_out_nrm.x;
    assign o_normal_y    = r_out_nrm.y;
    assign o_normal_z    = r_out_nrm.z;
    assign o_tex_u       = r_tex_u;
    assign o_tex_v       = r_tex_v;
    assign o_last_vertex = r_last;

    // a vertex strobe only appears while a sample is being processed
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> busy) else $error("vertex strobe while idle");

    // an accepted sample always occupies the block next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("accepted sample did not start processing");

    // normalizer results arrive only while they are awaited
    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        norm_done |-> (r_state == S_NORM)) else $error("stray normalizer result");

    // divider results arrive only during the texture steps
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVU || r_state == S_DIVV))
        else $error("stray divider result");

endmodule

// ----- rtl/core/hmtn_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module hmtn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/hmtn_norm.sv -----
// Iterative normalizer: turns a normal sum into a rounded Q1.14 unit vector.
module hmtn_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  hmtn_pkg::t_sums i_sums,
    output logic           o_done,
    output hmtn_pkg::t_norm o_norm
);

    localparam int MSQ_W  = 2 * hmtn_pkg::SUM_W;
    localparam int LEN_W  = MSQ_W + 2;
    localparam int TSQ_W  = 32;
    localparam int PROD_W = TSQ_W + LEN_W;
    localparam int RHS_SH = 30;

    localparam logic [2:0] N_IDLE = 3'd0;
    localparam logic [2:0] N_SQ   = 3'd1;
    localparam logic [2:0] N_LEN  = 3'd2;
    localparam logic [2:0] N_A    = 3'd3;
    localparam logic [2:0] N_B    = 3'd4;
    localparam logic [2:0] N_C    = 3'd5;

    logic [2:0]                      r_state;
    logic [1:0]                      r_j;
    logic [3:0]                      r_bit;
    logic [hmtn_pkg::LO_W-1:0]       r_lo;
    logic [hmtn_pkg::SUM_W-1:0]      r_mag [3];
    logic                            r_neg [3];
    logic [MSQ_W-1:0]                r_msq [3];
    logic [LEN_W-1:0]                r_len2;
    logic [TSQ_W-1:0]                r_tsq;
    logic [PROD_W-1:0]               r_prod;
    logic signed [hmtn_pkg::NRM_W-1:0] r_res [3];
    logic                            r_done;

    logic [hmtn_pkg::LO_W-1:0]       cand;
    logic [15:0]                     t_odd;
    logic [PROD_W-1:0]               rhs;
    logic                            fits;

    function automatic logic [hmtn_pkg::SUM_W-1:0] f_mag(
        input logic signed [hmtn_pkg::SUM_W-1:0] s);
        if (s < 0) return hmtn_pkg::SUM_W'(-s);
        else       return hmtn_pkg::SUM_W'(s);
    endfunction

    // candidate for the current bit and its odd test value 2*cand-1
    assign cand  = r_lo | (hmtn_pkg::LO_W'(1) << r_bit);
    assign t_odd = 16'({cand, 1'b0}) - 16'd1;
    assign rhs   = PROD_W'({r_msq[r_j], RHS_SH'(0)});
    assign fits  = (cand <= hmtn_pkg::LO_W'(hmtn_pkg::ONE_Q14)) && (r_prod <= rhs);

    // sequencer: squares, length, then a greedy bit search per component
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
            r_j     <= '0;
            r_bit   <= '0;
            r_lo    <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_mag[0] <= f_mag(i_sums.x);
                        r_mag[1] <= f_mag(i_sums.y);
                        r_mag[2] <= f_mag(i_sums.z);
                        r_neg[0] <= i_sums.x < 0;
                        r_neg[1] <= i_sums.y < 0;
                        r_neg[2] <= i_sums.z < 0;
                        r_j      <= '0;
                        r_state  <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_msq[r_j] <= MSQ_W'(r_mag[r_j] * r_mag[r_j]);
                    if (r_j == 2'd2) begin
                        r_state <= N_LEN;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                N_LEN: begin
                    r_len2  <= LEN_W'(r_msq[0]) + LEN_W'(r_msq[1]) + LEN_W'(r_msq[2]);
                    r_j     <= '0;
                    r_lo    <= '0;
                    r_bit   <= 4'(hmtn_pkg::LO_TOP);
                    r_state <= N_A;
                end
                N_A: begin
                    r_tsq   <= TSQ_W'(t_odd * t_odd);
                    r_state <= N_B;
                end
                N_B: begin
                    r_prod  <= PROD_W'(r_tsq * r_len2);
                    r_state <= N_C;
                end
                N_C: begin
                    if (r_bit == 4'd0) begin
                        // component finished: apply sign
                        if (r_neg[r_j]) begin
                            r_res[r_j] <= -hmtn_pkg::NRM_W'(fits ? cand : r_lo);
                        end else begin
                            r_res[r_j] <= hmtn_pkg::NRM_W'(fits ? cand : r_lo);
                        end
                        if (r_j == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= N_IDLE;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_lo    <= '0;
                            r_bit   <= 4'(hmtn_pkg::LO_TOP);
                            r_state <= N_A;
                        end
                    end else begin
                        if (fits) begin
                            r_lo <= cand;
                        end
                        r_bit   <= r_bit - 4'd1;
                        r_state <= N_A;
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_norm.x = r_res[0];
    assign o_norm.y = r_res[1];
    assign o_norm.z = r_res[2];

endmodule

// ----- rtl/core/hmtn_div.sv -----
// Bit-serial divider for texture coordinates: round(65536*num/(den_m1)).
module hmtn_div #(
    parameter int DW = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DW-1:0]               i_num,
    input  logic [DW-1:0]               i_den_m1,
    output logic                        o_done,
    output logic [hmtn_pkg::TEX_W-1:0]  o_quot
);

    localparam int RW = DW + 1;
    localparam int QW = hmtn_pkg::TEX_W;

    logic                r_run;
    logic                r_done;
    logic [4:0]          r_cnt;
    logic [RW-1:0]       r_rem;
    logic [RW-1:0]       r_den;
    logic [QW-1:0]       r_low;
    logic [QW-1:0]       r_q;

    logic [RW:0]         trial;
    logic                ge;

    // numerator is num*2^17 + den_m1; its high part num is already below 2*den_m1
    assign trial = {r_rem, r_low[QW-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'(QW - 1);
                r_rem <= RW'(i_num);
                r_den <= {i_den_m1, 1'b0};
                r_low <= QW'(i_den_m1);
                r_q   <= '0;
            end else if (r_run) begin
                r_rem <= ge ? RW'(trial - {1'b0, r_den}) : RW'(trial);
                r_q   <= {r_q[QW-2:0], ge};
                r_low <= {r_low[QW-2:0], 1'b0};
                if (r_cnt == 5'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
